/* hw/rtl/g2l_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the glyph to LCD pixel stream block.
package g2l_pkg;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_ROW   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CLIPPED  = 2'd1;
    localparam logic [1:0] ST_BAD_CODE = 2'd2;
    localparam logic [1:0] ST_NO_GLYPH = 2'd3;

    localparam logic [7:0] CMD_COLUMN = 8'h2A;
    localparam logic [7:0] CMD_ROW    = 8'h2B;
    localparam logic [7:0] CMD_WRITE  = 8'h2C;

    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0] LAST_PRINTABLE  = 8'd126;

    localparam logic [2:0] CFG_GLYPH_W  = 3'd0;
    localparam logic [2:0] CFG_GLYPH_H  = 3'd1;
    localparam logic [2:0] CFG_SCREEN_W = 3'd2;
    localparam logic [2:0] CFG_SCREEN_H = 3'd3;
    localparam logic [2:0] CFG_COL_OFS  = 3'd4;
    localparam logic [2:0] CFG_ROW_OFS  = 3'd5;

    localparam logic [4:0] RST_GLYPH_W  = 5'd8;
    localparam logic [5:0] RST_GLYPH_H  = 6'd16;
    localparam logic [8:0] RST_SCREEN_W = 9'd240;
    localparam logic [8:0] RST_SCREEN_H = 9'd135;
    localparam logic [8:0] RST_COL_OFS  = 9'd40;
    localparam logic [8:0] RST_ROW_OFS  = 9'd53;

    localparam logic [3:0] WIN_COL_CMD  = 4'd0;
    localparam logic [3:0] WIN_COL_S_HI = 4'd1;
    localparam logic [3:0] WIN_COL_S_LO = 4'd2;
    localparam logic [3:0] WIN_COL_E_HI = 4'd3;
    localparam logic [3:0] WIN_COL_E_LO = 4'd4;
    localparam logic [3:0] WIN_ROW_CMD  = 4'd5;
    localparam logic [3:0] WIN_ROW_S_HI = 4'd6;
    localparam logic [3:0] WIN_ROW_S_LO = 4'd7;
    localparam logic [3:0] WIN_ROW_E_HI = 4'd8;
    localparam logic [3:0] WIN_ROW_E_LO = 4'd9;
    localparam logic [3:0] WIN_WR_CMD   = 4'd10;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] font_index;
        logic [15:0] font_bits;
        logic [8:0]  pos_x;
        logic [8:0]  pos_y;
        logic [7:0]  char_code;
        logic [15:0] fg_color;
        logic [15:0] bg_color;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
        logic [1:0] status;
    } t_out;

    typedef enum logic [1:0] {
        SEL_REJECT,
        SEL_WINDOW,
        SEL_PIXEL
    } t_sel;

    typedef struct packed {
        logic       take;
        logic       capture;
        logic       emit;
        t_sel       sel;
        logic [3:0] win_idx;
        logic       pix_lo;
        logic       last;
    } t_ctl;

    typedef struct packed {
        logic       go_reject;
        logic       go_window;
        logic       go_row;
        logic       out_free;
        logic [4:0] gw;
    } t_sts;

endpackage

/* hw/rtl/g2l_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, registered-read RAM.
module g2l_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/g2l_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine sequencing rejects, window bytes and pixel rows.
module g2l_ctrl #(
    parameter int MAX_GLYPH_W = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  g2l_pkg::t_sts i_sts,
    output g2l_pkg::t_ctl o_ctl
);
    import g2l_pkg::*;

    localparam int CNT_W = ($clog2(2 * MAX_GLYPH_W) > 4) ? $clog2(2 * MAX_GLYPH_W) : 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REJ,
        S_WIN,
        S_FETCH,
        S_ROW
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] pix_last;

    assign pix_last   = CNT_W'({1'b0, i_sts.gw, 1'b0} - 7'd1);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.take = 1'b1;
                    n_cnt      = '0;
                    if (i_sts.go_reject) begin
                        n_state = S_REJ;
                    end else if (i_sts.go_window) begin
                        n_state = S_WIN;
                    end else if (i_sts.go_row) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_REJ: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.sel  = SEL_REJECT;
                    o_ctl.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_WIN: begin
                if (i_sts.out_free) begin
                    o_ctl.emit    = 1'b1;
                    o_ctl.sel     = SEL_WINDOW;
                    o_ctl.win_idx = r_cnt[3:0];
                    o_ctl.last    = (r_cnt[3:0] == WIN_WR_CMD);
                    if (r_cnt[3:0] == WIN_WR_CMD) begin
                        n_state = S_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_FETCH: begin
                o_ctl.capture = 1'b1;
                n_cnt         = '0;
                n_state       = S_ROW;
            end
            S_ROW: begin
                if (i_sts.out_free) begin
                    o_ctl.emit   = 1'b1;
                    o_ctl.sel    = SEL_PIXEL;
                    o_ctl.pix_lo = r_cnt[0];
                    o_ctl.last   = (r_cnt == pix_last);
                    if (r_cnt == pix_last) begin
                        n_state = S_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* hw/rtl/g2l_dpath.sv */
`timescale 1ns / 1ps
// Datapath: configuration, glyph state, font memory, window sums and output register.
module g2l_dpath #(
    parameter int FONT_DEPTH  = 4096,
    parameter int MAX_GLYPH_W = 16,
    parameter int MAX_GLYPH_H = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  g2l_pkg::t_in  i_in,
    input  g2l_pkg::t_ctl i_ctl,
    output g2l_pkg::t_sts o_sts,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [8:0]    i_cfg_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output g2l_pkg::t_out o_out
);
    import g2l_pkg::*;

    localparam int ADDR_W = $clog2(FONT_DEPTH);

    logic [4:0]  r_glyph_w;
    logic [5:0]  r_glyph_h;
    logic [8:0]  r_screen_w;
    logic [8:0]  r_screen_h;
    logic [8:0]  r_col_ofs;
    logic [8:0]  r_row_ofs;

    logic        r_active;
    logic [6:0]  r_glyph;
    logic [5:0]  r_next_row;
    logic [15:0] r_fg;
    logic [15:0] r_bg;

    logic [1:0]  r_status;
    logic [10:0] r_col_s;
    logic [10:0] r_col_e;
    logic [10:0] r_row_s;
    logic [10:0] r_row_e;
    logic [15:0] r_bits;

    logic        r_out_valid;
    t_out        r_out;
    t_out        n_out;

    logic [4:0]  gw;
    logic [5:0]  gh;
    logic        clip;
    logic        bad_code;
    logic        is_start;
    logic        is_row;
    logic [5:0]  row_inc;
    logic [11:0] row_slot;
    logic [15:0] rdata;
    logic [15:0] color;

    always_comb begin
        if (r_glyph_w == 5'd0) begin
            gw = 5'd1;
        end else if (r_glyph_w > 5'(MAX_GLYPH_W)) begin
            gw = 5'(MAX_GLYPH_W);
        end else begin
            gw = r_glyph_w;
        end
        if (r_glyph_h == 6'd0) begin
            gh = 6'd1;
        end else if (r_glyph_h > 6'(MAX_GLYPH_H)) begin
            gh = 6'(MAX_GLYPH_H);
        end else begin
            gh = r_glyph_h;
        end
    end

    assign clip = (({1'b0, i_in.pos_x} + {5'd0, gw}) > {1'b0, r_screen_w})
               || (({1'b0, i_in.pos_y} + {4'd0, gh}) > {1'b0, r_screen_h});
    assign bad_code = (i_in.char_code < FIRST_PRINTABLE) || (i_in.char_code > LAST_PRINTABLE);
    assign is_start = (i_in.req_type == REQ_START);
    assign is_row   = (i_in.req_type == REQ_ROW);

    assign o_sts.go_reject = (is_start && (clip || bad_code)) || (is_row && !r_active);
    assign o_sts.go_window = is_start && !clip && !bad_code;
    assign o_sts.go_row    = is_row && r_active;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.gw        = gw;

    assign row_slot = {5'd0, r_glyph} * 12'd32 + {7'd0, r_next_row[4:0]};
    assign row_inc  = r_next_row + 6'd1;

    g2l_ram #(
        .WIDTH (16),
        .DEPTH (FONT_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.take && (i_in.req_type == REQ_LOAD)),
        .i_waddr (ADDR_W'(i_in.font_index)),
        .i_wdata (i_in.font_bits),
        .i_re    (i_ctl.take && o_sts.go_row),
        .i_raddr (ADDR_W'(row_slot)),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_w  <= RST_GLYPH_W;
            r_glyph_h  <= RST_GLYPH_H;
            r_screen_w <= RST_SCREEN_W;
            r_screen_h <= RST_SCREEN_H;
            r_col_ofs  <= RST_COL_OFS;
            r_row_ofs  <= RST_ROW_OFS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GLYPH_W:  r_glyph_w  <= i_cfg_data[4:0];
                CFG_GLYPH_H:  r_glyph_h  <= i_cfg_data[5:0];
                CFG_SCREEN_W: r_screen_w <= i_cfg_data;
                CFG_SCREEN_H: r_screen_h <= i_cfg_data;
                CFG_COL_OFS:  r_col_ofs  <= i_cfg_data;
                CFG_ROW_OFS:  r_row_ofs  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_glyph    <= '0;
            r_next_row <= '0;
            r_fg       <= '0;
            r_bg       <= '0;
        end else if (i_ctl.take) begin
            if (is_start) begin
                if (clip || bad_code) begin
                    r_active <= 1'b0;
                end else begin
                    r_active   <= 1'b1;
                    r_glyph    <= 7'(i_in.char_code - FIRST_PRINTABLE);
                    r_next_row <= '0;
                    r_fg       <= i_in.fg_color;
                    r_bg       <= i_in.bg_color;
                end
            end
        end else if (i_ctl.capture) begin
            if (row_inc >= gh) begin
                r_active   <= 1'b0;
                r_next_row <= '0;
            end else begin
                r_next_row <= row_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            if (is_start) begin
                r_status <= clip ? ST_CLIPPED : ST_BAD_CODE;
            end else begin
                r_status <= ST_NO_GLYPH;
            end
            r_col_s <= {2'd0, i_in.pos_x} + {2'd0, r_col_ofs};
            r_col_e <= {2'd0, i_in.pos_x} + {6'd0, gw} - 11'd1 + {2'd0, r_col_ofs};
            r_row_s <= {2'd0, i_in.pos_y} + {2'd0, r_row_ofs};
            r_row_e <= {2'd0, i_in.pos_y} + {5'd0, gh} - 11'd1 + {2'd0, r_row_ofs};
        end
        if (i_ctl.capture) begin
            r_bits <= rdata;
        end else if (i_ctl.emit && (i_ctl.sel == SEL_PIXEL) && i_ctl.pix_lo) begin
            r_bits <= {r_bits[14:0], 1'b0};
        end
    end

    assign color = r_bits[15] ? r_fg : r_bg;

    always_comb begin
        n_out         = '0;
        n_out.last    = i_ctl.last;
        n_out.status  = ST_OK;
        n_out.is_data = 1'b1;
        case (i_ctl.sel)
            SEL_REJECT: begin
                n_out.is_data = 1'b0;
                n_out.status  = r_status;
            end
            SEL_WINDOW: begin
                unique case (i_ctl.win_idx)
                    WIN_COL_CMD: begin
                        n_out.out_byte = CMD_COLUMN;
                        n_out.is_data  = 1'b0;
                    end
                    WIN_COL_S_HI: n_out.out_byte = {5'd0, r_col_s[10:8]};
                    WIN_COL_S_LO: n_out.out_byte = r_col_s[7:0];
                    WIN_COL_E_HI: n_out.out_byte = {5'd0, r_col_e[10:8]};
                    WIN_COL_E_LO: n_out.out_byte = r_col_e[7:0];
                    WIN_ROW_CMD: begin
                        n_out.out_byte = CMD_ROW;
                        n_out.is_data  = 1'b0;
                    end
                    WIN_ROW_S_HI: n_out.out_byte = {5'd0, r_row_s[10:8]};
                    WIN_ROW_S_LO: n_out.out_byte = r_row_s[7:0];
                    WIN_ROW_E_HI: n_out.out_byte = {5'd0, r_row_e[10:8]};
                    WIN_ROW_E_LO: n_out.out_byte = r_row_e[7:0];
                    WIN_WR_CMD: begin
                        n_out.out_byte = CMD_WRITE;
                        n_out.is_data  = 1'b0;
                    end
                    default: n_out.out_byte = '0;
                endcase
            end
            SEL_PIXEL: begin
                n_out.out_byte = i_ctl.pix_lo ? color[7:0] : color[15:8];
            end
            default: n_out.out_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* hw/rtl/glyph_to_lcd_pixel_stream_core.sv */
`timescale 1ns / 1ps
// Top level of the glyph to LCD pixel stream block.
//
// Input channel (i_in_valid / o_in_stall, payload i_in) carries requests:
// load a font row word, start a glyph, or emit the next glyph row.
// Output channel (o_out_valid / i_out_stall, payload o_out) carries display
// bytes, each tagged command or data, with last set on the final byte of a
// transaction and a status code on rejects.
// Configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce it. A start emits 11 window bytes (one byte
// for a reject); a row reads the font memory, then emits 2 * glyph width
// pixel bytes (one byte for a reject). The byte-wide output register sets
// the rate: one byte per cycle while the receiver does not stall. Requests
// are taken one at a time; o_in_stall is high while one is in work. A stalled
// receiver freezes the output register and the sequence; nothing is lost.
// Reset clears the glyph state, restores register defaults and empties the
// output; the font memory keeps its contents.
module glyph_to_lcd_pixel_stream_core #(
    parameter int FONT_DEPTH  = 4096,
    parameter int MAX_GLYPH_W = 16,
    parameter int MAX_GLYPH_H = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  g2l_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output g2l_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [8:0]    i_cfg_data
);
    import g2l_pkg::*;

    t_ctl ctl;
    t_sts sts;

    g2l_ctrl #(
        .MAX_GLYPH_W (MAX_GLYPH_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    g2l_dpath #(
        .FONT_DEPTH  (FONT_DEPTH),
        .MAX_GLYPH_W (MAX_GLYPH_W),
        .MAX_GLYPH_H (MAX_GLYPH_H)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

/* hw/rtl/g2l_checker.sv */
`timescale 1ns / 1ps
// Port-level assertions for the glyph to LCD pixel stream block, with bind.
module g2l_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input g2l_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input g2l_pkg::t_out o_out
);
    import g2l_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output transaction changed");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall
            && (i_in.req_type == REQ_START || i_in.req_type == REQ_ROW)
        |=> o_in_stall)
        else $error("input not stalled while a transaction is in work");

    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_OK
        |-> o_out.last && !o_out.is_data && o_out.out_byte == 8'd0)
        else $error("malformed reject byte");

    a_cmd_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.is_data && o_out.status == ST_OK
        |-> o_out.out_byte == CMD_COLUMN || o_out.out_byte == CMD_ROW
            || o_out.out_byte == CMD_WRITE)
        else $error("unknown command byte");

    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind glyph_to_lcd_pixel_stream_core g2l_checker u_g2l_checker (.*);
